[sv/hup_pkg.sv]
// ----------------------------------------------------------------------------
// hup_pkg
// Shared constants and types for the Horn SAT unit propagation block.
// ----------------------------------------------------------------------------
package hup_pkg;

    localparam int MAX_VARS    = 64;
    localparam int MAX_CLAUSES = 256;

    localparam int VAR_IDX_W = $clog2(MAX_VARS);
    localparam int VC_W      = 7;
    localparam int CC_W      = 9;
    localparam int CL_ADDR_W = $clog2(MAX_CLAUSES);
    localparam int CL_CNT_W  = CL_ADDR_W + 1;
    localparam int ROW_W     = 2 * MAX_VARS;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAUSE_COUNT = 1'b1;

    localparam logic signed [1:0] LIT_NEG = 2'sb00;
    localparam logic signed [1:0] LIT_POS = 2'sb01;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_FLUSH,
        ST_SCAN,
        ST_DONE
    } hup_state_t;

endpackage

[sv/hup_ifs.sv]
// ----------------------------------------------------------------------------
// hup_ifs
// Word channels: formula entries in, verdicts out.
// ----------------------------------------------------------------------------
interface hup_entry_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] literal;
    logic              last;

    modport source (output valid, literal, last, input ready);
    modport sink   (input valid, literal, last, output ready);
endinterface

interface hup_verdict_if;
    logic valid;
    logic ready;
    logic unsatisfiable;

    modport source (output valid, unsatisfiable, input ready);
    modport sink   (input valid, unsatisfiable, output ready);
endinterface

[sv/horn_sat_unit_propagation.sv]
// ----------------------------------------------------------------------------
// horn_sat_unit_propagation
// Loads a CNF formula one entry per word, then runs unit propagation.
// ----------------------------------------------------------------------------
// After reset the block clears all 256 rows of the clause RAM, so clauses
// never loaded read as empty; no entry words are taken meanwhile. Loading
// takes one entry word per cycle. Clauses live in a 256 x 128 RAM
// (positive and negative masks); each clause row is assembled in a register
// and merged into the RAM once complete. After the last word, propagation
// scans the RAM one clause per cycle in rounds, repeated until a round
// assigns nothing; the verdict word is then offered, or earlier once a
// conflict is found. No entry words are taken until the verdict is
// registered.
module horn_sat_unit_propagation (
    input  logic                            clk,
    input  logic                            rst_n,
    hup_entry_if.sink                       in,
    hup_verdict_if.source                   out,
    input  logic                            cfg_we,
    input  logic [hup_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hup_pkg::CFG_W-1:0]       cfg_data
);
    import hup_pkg::*;

    hup_state_t state_reg, state_next;

    logic [VC_W-1:0]       vc_reg;
    logic [CC_W-1:0]       cc_reg;
    logic [VC_W-1:0]       vc_eff;
    logic [CC_W-1:0]       cc_eff;
    logic [VAR_IDX_W-1:0]  vc_m1;
    logic [MAX_VARS-1:0]   vmask;

    logic [VAR_IDX_W-1:0]  var_idx_reg, var_idx_next;
    logic [CL_CNT_W-1:0]   clause_idx_reg, clause_idx_next;
    logic [MAX_VARS-1:0]   newp_reg, newp_next, newn_reg, newn_next;
    logic [MAX_VARS-1:0]   wmask_reg, wmask_next;
    logic [ROW_W-1:0]      old_reg;
    logic                  old_fresh_reg, old_fresh_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [CL_ADDR_W-1:0]  wr_addr_reg, wr_addr_next;

    logic [CL_CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic                  ev_last_reg, ev_last_next;
    logic                  changed_reg, changed_next;
    logic [MAX_VARS-1:0]   amask_reg, amask_next, aval_reg, aval_next;
    logic                  verdict_reg, verdict_next;
    logic                  ovalid_reg, ovalid_next;
    logic                  ounsat_reg, ounsat_next;

    logic                  accept, full, store;
    logic [MAX_VARS-1:0]   bitsel, base_p, base_n, base_w;
    logic [ROW_W-1:0]      old_row, wdata, rdata;
    logic                  ram_re;
    logic [CL_ADDR_W-1:0]  raddr;
    logic                  issue;
    logic                  clearing, ram_we;
    logic [CL_ADDR_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;

    logic [MAX_VARS-1:0]   pos, neg, truth, open_v;
    logic                  conflict, unit;

    // effective config
    always_comb
    begin
        if (vc_reg == '0)
            vc_eff = VC_W'(1);
        else if (vc_reg > VC_W'(MAX_VARS))
            vc_eff = VC_W'(MAX_VARS);
        else
            vc_eff = vc_reg;
        if (cc_reg == '0)
            cc_eff = CC_W'(1);
        else if (cc_reg > CC_W'(MAX_CLAUSES))
            cc_eff = CC_W'(MAX_CLAUSES);
        else
            cc_eff = cc_reg;
        vc_m1 = VAR_IDX_W'(vc_eff - VC_W'(1));
        if (vc_eff >= VC_W'(MAX_VARS))
            vmask = '1;
        else
            vmask = (MAX_VARS'(1) << vc_eff) - MAX_VARS'(1);
    end

    assign in.ready         = (state_reg == ST_LOAD);
    assign out.valid        = ovalid_reg;
    assign out.unsatisfiable = ounsat_reg;

    assign accept = in.valid && in.ready;
    assign full   = ({1'b0, clause_idx_reg} >= {1'b0, cc_eff});
    assign store  = accept && !full;
    assign bitsel = MAX_VARS'(1) << var_idx_reg;

    // merge pending row with old RAM contents
    assign old_row = old_fresh_reg ? rdata : old_reg;
    assign wdata = {(old_row[ROW_W-1:MAX_VARS] & ~wmask_reg) | newn_reg,
                    (old_row[MAX_VARS-1:0] & ~wmask_reg) | newp_reg};

    // clearing pass writes zero rows, one per cycle
    assign clearing  = (state_reg == ST_CLEAR);
    assign ram_we    = wr_pend_reg || clearing;
    assign ram_waddr = clearing ? rd_idx_reg[CL_ADDR_W-1:0] : wr_addr_reg;
    assign ram_wdata = clearing ? '0 : wdata;

    assign issue = (state_reg == ST_SCAN) && (rd_idx_reg < CL_CNT_W'(cc_eff));
    assign ram_re = issue || (store && var_idx_reg == '0);
    assign raddr  = (state_reg == ST_SCAN) ? rd_idx_reg[CL_ADDR_W-1:0]
                                           : clause_idx_reg[CL_ADDR_W-1:0];

    hup_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_CLAUSES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // clause evaluation
    always_comb
    begin
        pos      = rdata[MAX_VARS-1:0] & vmask;
        neg      = rdata[ROW_W-1:MAX_VARS] & vmask;
        truth    = (pos & amask_reg & aval_reg) | (neg & amask_reg & ~aval_reg);
        open_v   = (pos | neg) & ~amask_reg;
        conflict = ((pos | neg) == '0) || (truth == '0 && open_v == '0);
        unit     = (truth == '0) && (open_v != '0)
                   && ((open_v & (open_v - MAX_VARS'(1))) == '0);
    end

    always_comb
    begin
        state_next      = state_reg;
        var_idx_next    = var_idx_reg;
        clause_idx_next = clause_idx_reg;
        newp_next       = newp_reg;
        newn_next       = newn_reg;
        wmask_next      = wmask_reg;
        old_fresh_next  = store && (var_idx_reg == '0);
        wr_pend_next    = 1'b0;
        wr_addr_next    = clause_idx_reg[CL_ADDR_W-1:0];
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = issue;
        ev_last_next    = issue && (rd_idx_reg == CL_CNT_W'(cc_eff - CC_W'(1)));
        changed_next    = changed_reg;
        amask_next      = amask_reg;
        aval_next       = aval_reg;
        verdict_next    = verdict_reg;
        ovalid_next     = ovalid_reg && !out.ready;
        ounsat_next     = ounsat_reg;
        base_p          = (var_idx_reg == '0) ? '0 : newp_reg;
        base_n          = (var_idx_reg == '0) ? '0 : newn_reg;
        base_w          = (var_idx_reg == '0) ? '0 : wmask_reg;

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CL_CNT_W'(1);
        end

        if (store)
        begin
            newp_next  = (base_p & ~bitsel) | ((in.literal == LIT_POS) ? bitsel : '0);
            newn_next  = (base_n & ~bitsel) | ((in.literal == LIT_NEG) ? bitsel : '0);
            wmask_next = base_w | bitsel;
            wr_pend_next = (var_idx_reg == vc_m1) || in.last;
            if (var_idx_reg == vc_m1)
            begin
                var_idx_next    = '0;
                clause_idx_next = clause_idx_reg + CL_CNT_W'(1);
            end
            else
            begin
                var_idx_next = var_idx_reg + VAR_IDX_W'(1);
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                rd_idx_next = rd_idx_reg + CL_CNT_W'(1);
                if (rd_idx_reg == CL_CNT_W'(MAX_CLAUSES - 1))
                begin
                    rd_idx_next = '0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (accept && in.last)
                begin
                    var_idx_next    = '0;
                    clause_idx_next = '0;
                    rd_idx_next     = '0;
                    amask_next      = '0;
                    aval_next       = '0;
                    changed_next    = 1'b0;
                    state_next      = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (ev_valid_reg)
                begin
                    if (conflict)
                    begin
                        verdict_next  = 1'b1;
                        ev_valid_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        if (unit)
                        begin
                            amask_next   = amask_reg | open_v;
                            aval_next    = ((pos & open_v) != '0) ? (aval_reg | open_v)
                                                                  : (aval_reg & ~open_v);
                            changed_next = 1'b1;
                        end
                        if (ev_last_reg)
                        begin
                            if (changed_reg || unit)
                            begin
                                rd_idx_next  = '0;
                                changed_next = 1'b0;
                            end
                            else
                            begin
                                verdict_next = 1'b0;
                                state_next   = ST_DONE;
                            end
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    ounsat_next = verdict_reg;
                    state_next  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            vc_reg         <= VC_W'(MAX_VARS);
            cc_reg         <= CC_W'(MAX_CLAUSES);
            var_idx_reg    <= '0;
            clause_idx_reg <= '0;
            old_fresh_reg  <= 1'b0;
            wr_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            ev_last_reg    <= 1'b0;
            changed_reg    <= 1'b0;
            amask_reg      <= '0;
            aval_reg       <= '0;
            verdict_reg    <= 1'b0;
            ovalid_reg     <= 1'b0;
            ounsat_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we && cfg_index == CFG_VAR_COUNT)
                vc_reg <= cfg_data[VC_W-1:0];
            if (cfg_we && cfg_index == CFG_CLAUSE_COUNT)
                cc_reg <= cfg_data[CC_W-1:0];
            var_idx_reg    <= var_idx_next;
            clause_idx_reg <= clause_idx_next;
            old_fresh_reg  <= old_fresh_next;
            wr_pend_reg    <= wr_pend_next;
            rd_idx_reg     <= rd_idx_next;
            ev_valid_reg   <= ev_valid_next;
            ev_last_reg    <= ev_last_next;
            changed_reg    <= changed_next;
            amask_reg      <= amask_next;
            aval_reg       <= aval_next;
            verdict_reg    <= verdict_next;
            ovalid_reg     <= ovalid_next;
            ounsat_reg     <= ounsat_next;
        end
    end

    // row assembly, no reset
    always_ff @(posedge clk)
    begin
        newp_reg    <= newp_next;
        newn_reg    <= newn_next;
        wmask_reg   <= wmask_next;
        wr_addr_reg <= wr_addr_next;
        if (old_fresh_reg)
            old_reg <= rdata;
    end

endmodule

[sv/hup_ram.sv]
// ----------------------------------------------------------------------------
// hup_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/hup_checker.sv]
// ----------------------------------------------------------------------------
// hup_checker
// Port-level checks for the unit propagation block.
// ----------------------------------------------------------------------------
module hup_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_unsat
);

    // held verdict stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_unsat))
        else $error("verdict dropped or changed while stalled");

    // no entries taken right after the last one
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("entry port open during propagation");

    // a verdict only appears after a propagation run
    a_verdict_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("verdict without propagation");

endmodule

bind horn_sat_unit_propagation hup_checker u_hup_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .in_last   (in.last),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_unsat (out.unsatisfiable)
);
